// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the table core. Compiled to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: design/pst_pkg.sv
// ----------------------------------------------------------------------------
// Pareto staircase table package
// Field widths, command and status codes and shared types.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned KEY_W    = 48;
  localparam int unsigned BKEY_W   = 50;
  localparam int unsigned VAL_W    = 48;
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned OFS_W    = 49;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ENTRY_W  = BKEY_W + VAL_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SHIFT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DOMINATED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd3;

  // One stored table entry: biased key above value.
  typedef struct packed {
    logic [BKEY_W-1:0] bkey;
    logic [VAL_W-1:0]  value;
  } entry_t;

  // Offset unit results.
  typedef struct packed {
    logic [BKEY_W-1:0] bkey;
    logic [OFS_W-1:0]  ofs_next;
    logic              sat;
  } ofs_res_t;

endpackage

// File: design/pareto_staircase_table_core.sv
// ----------------------------------------------------------------------------
// Pareto staircase table core
// Sorted key/value table in which keys and values both rise, with a global
// saturating key offset; insert, shift and successor query commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   insert, shift or query. Every command returns exactly one result on the
//   output channel (out_valid_o/out_ready_i): found, value_out and status.
//   The block handles one command at a time; in_ready_o is high only while
//   the sequencer is idle.
//   The scan reads one entry per cycle from the single table RAM port pair;
//   each moved entry is one read and one write, streamed one per cycle.
//   The next command is accepted at the earliest in the cycle after a result is loaded.
//   The result sits in an output register; a new command is accepted while
//   it waits. If the receiver stalls, a finished command holds in its last
//   step until the output register is free.
//   Reset empties the table (count zero) and clears the offset; the RAM
//   itself is not cleared since entries at or above the count are never used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pareto_staircase_table_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pst_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [pst_pkg::KEY_W-1:0]    key_i,
  input  logic [pst_pkg::VAL_W-1:0]           value_in_i,
  input  logic signed [pst_pkg::DELTA_W-1:0]  delta_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic [pst_pkg::VAL_W-1:0]           value_out_o,
  output logic [pst_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a command
  localparam logic [2:0] S_SCAN  = 3'd1;  // walk the table for the lower bound
  localparam logic [2:0] S_MOVE  = 3'd2;  // stream entries up or down
  localparam logic [2:0] S_WRNEW = 3'd3;  // write the new entry, commit count
  localparam logic [2:0] S_RES   = 3'd4;  // hand result to output register

  // Control registers
  logic [2:0]                     state_q, state_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [pst_pkg::OFS_W-1:0]      ofs_q, ofs_d;
  logic                           pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;

  // Payload registers
  logic [pst_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  logic [pst_pkg::BKEY_W-1:0]     bkey_q, bkey_d;
  logic [pst_pkg::VAL_W-1:0]      val_q, val_d;
  logic [CW-1:0]                  idx_q, idx_d;
  logic [CW-1:0]                  j_q, j_d;
  logic                           j_hit_q, j_hit_d;
  logic [CW-1:0]                  rd_q, rd_d;
  logic [CW-1:0]                  wr_q, wr_d;
  logic [CW-1:0]                  rem_q, rem_d;
  logic                           up_q, up_d;
  logic [CW-1:0]                  cnt_new_q, cnt_new_d;
  logic                           res_found_q, res_found_d;
  logic [pst_pkg::VAL_W-1:0]      res_value_q, res_value_d;
  logic [pst_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic                           out_found_q, out_found_d;
  logic [pst_pkg::VAL_W-1:0]      out_value_q, out_value_d;
  logic [pst_pkg::STATUS_W-1:0]   out_status_q, out_status_d;

  // RAM port
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [pst_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [pst_pkg::ENTRY_W-1:0]    ram_rdata;
  pst_pkg::entry_t                rd_entry;

  // Scan decision terms
  pst_pkg::ofs_res_t              alu_res;
  logic                           in_xfer;
  logic [CW-1:0]                  idx_inc;
  logic                           at_end;
  logic                           key_ge;
  logic                           hit;
  logic                           overwrite;
  logic [CW-1:0]                  jpos;
  logic [CW-1:0]                  jnext;
  logic [CW-1:0]                  src;
  logic                           out_free;

  pst_offset_alu u_ofs_alu (
    .ofs_i   (ofs_q),
    .key_i   (key_i),
    .delta_i (delta_i),
    .res_o   (alu_res)
  );

  pst_ram #(
    .WIDTH (pst_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry   = pst_pkg::entry_t'(ram_rdata);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Lower-bound compare on the entry returned this cycle (entry idx_q).
  assign idx_inc   = CW'(idx_q + 1'b1);
  assign at_end    = (idx_q == cnt_q);
  assign key_ge    = $signed(rd_entry.bkey) >= $signed(bkey_q);
  assign hit       = !at_end;
  assign overwrite = hit && (rd_entry.bkey == bkey_q);
  // First entry of the removed run, or the insert point when there is none.
  assign jpos      = j_hit_q ? j_q : idx_q;
  assign jnext     = CW'(jpos + 1'b1);
  // First surviving entry above the new one.
  assign src       = overwrite ? idx_inc : idx_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ofs_d        = ofs_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    cmd_d        = cmd_q;
    bkey_d       = bkey_q;
    val_d        = val_q;
    idx_d        = idx_q;
    j_d          = j_q;
    j_hit_d      = j_hit_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    rem_d        = rem_q;
    up_d         = up_q;
    cnt_new_d    = cnt_new_q;
    res_found_d  = res_found_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_found_d  = out_found_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    ram_we    = 1'b0;
    ram_waddr = wr_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = '0;

    // Drop the output once it is taken; a new result may refill it below.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        // Read of entry 0 goes out now so the scan starts with data.
        ram_raddr = '0;
        if (in_xfer) begin
          cmd_d        = cmd_i;
          bkey_d       = alu_res.bkey;
          val_d        = value_in_i;
          idx_d        = '0;
          j_hit_d      = 1'b0;
          res_found_d  = 1'b0;
          res_value_d  = '0;
          res_status_d = pst_pkg::STATUS_DONE;
          case (cmd_i)
            pst_pkg::CMD_INSERT, pst_pkg::CMD_QUERY: begin
              state_d = S_SCAN;
            end
            pst_pkg::CMD_SHIFT: begin
              ofs_d        = alu_res.ofs_next;
              res_status_d = alu_res.sat ? pst_pkg::STATUS_SATURATED
                                         : pst_pkg::STATUS_DONE;
              state_d      = S_RES;
            end
            default: begin
              state_d = S_RES;
            end
          endcase
        end
      end

      S_SCAN: begin
        ram_raddr = idx_inc[AW-1:0];
        if (at_end || key_ge) begin
          if (cmd_q == pst_pkg::CMD_QUERY) begin
            res_found_d = hit;
            res_value_d = hit ? rd_entry.value : '0;
            state_d     = S_RES;
          end else if (hit && (rd_entry.value <= val_q)) begin
            res_status_d = pst_pkg::STATUS_DOMINATED;
            state_d      = S_RES;
          end else if (!overwrite && (cnt_q == FULL_CNT)) begin
            res_status_d = pst_pkg::STATUS_FULL;
            state_d      = S_RES;
          end else begin
            j_d       = jpos;
            cnt_new_d = CW'(jnext + cnt_q - src);
            rem_d     = CW'(cnt_q - src);
            pend_d    = 1'b0;
            if (src > jnext) begin
              // Close the gap: move the tail down, lowest entry first.
              up_d = 1'b0;
              rd_d = src;
              wr_d = jnext;
            end else if (src == jnext) begin
              rem_d = '0;
              up_d  = 1'b0;
            end else begin
              // Open a slot: move the tail up by one, highest entry first.
              up_d = 1'b1;
              rd_d = CW'(cnt_q - 1'b1);
              wr_d = cnt_q;
            end
            state_d = S_MOVE;
          end
        end else begin
          idx_d = idx_inc;
          // Values rise, so the first one at or above the new value starts
          // the run that the insert removes.
          if (!j_hit_q && (rd_entry.value >= val_q)) begin
            j_hit_d = 1'b1;
            j_d     = idx_q;
          end
        end
      end

      S_MOVE: begin
        ram_raddr = rd_q[AW-1:0];
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[AW-1:0];
          ram_wdata = ram_rdata;
          wr_d      = up_q ? CW'(wr_q - 1'b1) : CW'(wr_q + 1'b1);
        end
        if (rem_q != '0) begin
          rd_d   = up_q ? CW'(rd_q - 1'b1) : CW'(rd_q + 1'b1);
          rem_d  = CW'(rem_q - 1'b1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_WRNEW;
          end
        end
      end

      S_WRNEW: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = {bkey_q, val_q};
        cnt_d     = cnt_new_q;
        state_d   = S_RES;
      end

      S_RES: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ofs_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ofs_q       <= ofs_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    bkey_q       <= bkey_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    j_q          <= j_d;
    j_hit_q      <= j_hit_d;
    rd_q         <= rd_d;
    wr_q         <= wr_d;
    rem_q        <= rem_d;
    up_q         <= up_d;
    cnt_new_q    <= cnt_new_d;
    res_found_q  <= res_found_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign value_out_o = out_value_q;
  assign status_o    = out_status_q;

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > FULL_CNT, "entry count above capacity")
  `ASSERT_ALWAYS(a_scan_bound, clk_i, rst_ni, (state_q == S_SCAN) |-> (idx_q <= cnt_q), "scan ran past the table")
  `ASSERT_NEVER(a_move_hazard, clk_i, rst_ni, (state_q == S_MOVE) && pend_q && (rem_q != '0) && (ram_waddr == ram_raddr), "move writes the entry it reads")
  `ASSERT_ALWAYS(a_cnt_hold, clk_i, rst_ni, (state_q != S_WRNEW) |=> $stable(cnt_q), "count changed outside commit")
  `ASSERT_ALWAYS(a_ofs_hold, clk_i, rst_ni, !(in_xfer && (cmd_i == pst_pkg::CMD_SHIFT)) |=> $stable(ofs_q), "offset changed without shift")

endmodule

// File: design/pst_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pst_offset_alu.sv
// ----------------------------------------------------------------------------
// Offset unit
// Biases an incoming key by the global offset and forms the saturated
// offset after a shift.
// ----------------------------------------------------------------------------
module pst_offset_alu (
  input  logic [pst_pkg::OFS_W-1:0]   ofs_i,
  input  logic [pst_pkg::KEY_W-1:0]   key_i,
  input  logic [pst_pkg::DELTA_W-1:0] delta_i,
  output pst_pkg::ofs_res_t           res_o
);

  localparam int unsigned BW = pst_pkg::BKEY_W;
  localparam int unsigned OW = pst_pkg::OFS_W;

  logic [BW-1:0] ofs_ext;
  logic [BW-1:0] sum;
  logic          sat;

  assign ofs_ext = {{(BW-OW){ofs_i[OW-1]}}, ofs_i};
  assign sum     = ofs_ext + {{(BW-pst_pkg::DELTA_W){delta_i[pst_pkg::DELTA_W-1]}}, delta_i};

  // The sum fits the offset range when its two top bits agree.
  assign sat = sum[BW-1] ^ sum[BW-2];

  assign res_o.bkey     = ofs_ext + {{(BW-pst_pkg::KEY_W){key_i[pst_pkg::KEY_W-1]}}, key_i};
  assign res_o.sat      = sat;
  assign res_o.ofs_next = !sat        ? sum[OW-1:0] :
                          sum[BW-1]   ? {1'b1, {(OW-1){1'b0}}} :
                                        {1'b0, {(OW-1){1'b1}}};

endmodule
